// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the SHA-256 hash engine.
// No dependencies; imported by every module of the engine.
package sha256_pkg;

  typedef logic [0:7][31:0]  hash_words_t;
  typedef logic [0:15][31:0] blk_words_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_beat_t;

  // Block buffer controls from the sequencer
  typedef struct packed {
    logic       byte_we;    // put byte_val at pos
    logic       zero_tail;  // clear words after the one holding pos
    logic       zero_low;   // clear words 0..13
    logic       len_we;     // write bit length into words 14 and 15
    logic       shift;      // advance message schedule one round
    logic [5:0] pos;
    logic [7:0] byte_val;
  } sched_ctl_t;

  // Round datapath controls
  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } round_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_UPD,
    ST_LEN,
    ST_EMIT
  } sha_state_t;

  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [5:0]  LAST_POS     = 6'd63;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;
  localparam logic [2:0]  LAST_WORD    = 3'd7;
  localparam int unsigned LEN_WORD_HI  = 14;
  localparam int unsigned LEN_WORD_LO  = 15;

  localparam hash_words_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] K_TABLE = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/sha256_hash_engine.sv =====
`timescale 1ns / 1ps
// SHA-256 engine top: sequencer, chaining state, byte count, digest output.
// Depends on sha256_pkg, sha256_sched and sha256_round.
//
//  channel | dir | beat type  | carries
//  msg     | in  | msg_beat_t | one message byte and/or end-of-message flag
//  dig     | out | dig_beat_t | one 32-bit digest word, eight per message
//
// A byte beat is accepted in IDLE; the 64th byte of a block starts compression and then the
// chaining add, both run by the single shared round unit, and no byte is taken meanwhile.
// An end-of-message beat adds a pad step, then one or two final blocks are compressed (with a
// length step before the second), then 8 digest beats are sent.
// msg_ready is low while a block compresses, and after a finish until word 7 is taken.
// Synchronous reset restores the initial hash and a zero byte count.
module sha256_hash_engine import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  msg_beat_t msg,
  output logic      dig_valid,
  input  logic      dig_ready,
  output dig_beat_t dig
);

  sha_state_t  state;
  sha_state_t  state_next;
  hash_words_t chain;
  hash_words_t v;
  logic [60:0] count;
  logic [5:0]  rnd;
  logic [2:0]  widx;
  logic        fin;
  logic        padded;
  logic        len_pend;
  logic [5:0]  pos;
  logic [31:0] w;
  sched_ctl_t  sctl;
  round_ctl_t  rctl;
  logic        msg_fire;
  logic        dig_fire;

  assign pos      = count[5:0];
  assign msg_fire = msg_valid && msg_ready;
  assign dig_fire = dig_valid && dig_ready;

  sha256_sched u_sched (
    .clk      (clk),
    .ctl      (sctl),
    .len_bits ({count, 3'd0}),
    .w        (w)
  );

  sha256_round u_round (
    .clk   (clk),
    .ctl   (rctl),
    .chain (chain),
    .w     (w),
    .v     (v)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          if (msg.has_byte && pos == LAST_POS) begin
            state_next = ST_COMP;
          end else if (msg.is_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD:  state_next = ST_COMP;
      ST_COMP: begin
        if (rnd == LAST_ROUND) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!fin) begin
          state_next = ST_IDLE;
        end else if (!padded) begin
          state_next = ST_PAD;
        end else if (len_pend) begin
          state_next = ST_LEN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_LEN:  state_next = ST_COMP;
      ST_EMIT: begin
        if (dig_ready && widx == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    msg_ready     = 1'b0;
    dig_valid     = 1'b0;
    sctl          = '0;
    sctl.pos      = pos;
    sctl.byte_val = msg.data_byte;
    rctl.load     = (state != ST_COMP) && (state_next == ST_COMP);
    rctl.step     = 1'b0;
    rctl.rnd      = rnd;
    case (state)
      ST_IDLE: begin
        msg_ready    = 1'b1;
        sctl.byte_we = msg_valid && msg.has_byte;
      end
      ST_PAD: begin
        sctl.byte_we   = 1'b1;
        sctl.zero_tail = 1'b1;
        sctl.byte_val  = PAD_BYTE;
        // length fits only when the pad byte lands before byte 56
        sctl.len_we    = (pos[5:3] != 3'b111);
      end
      ST_COMP: begin
        sctl.shift = 1'b1;
        rctl.step  = 1'b1;
      end
      ST_LEN: begin
        sctl.zero_low = 1'b1;
        sctl.len_we   = 1'b1;
      end
      ST_EMIT: begin
        dig_valid = 1'b1;
      end
      default: begin
        msg_ready = 1'b0;
      end
    endcase
  end

  assign dig.digest_word = chain[widx];
  assign dig.word_index  = widx;
  assign dig.last_word   = (widx == LAST_WORD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      chain    <= H_INIT;
      count    <= '0;
      rnd      <= '0;
      widx     <= '0;
      fin      <= 1'b0;
      padded   <= 1'b0;
      len_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (rctl.load) begin
        rnd <= '0;
      end else if (rctl.step) begin
        rnd <= rnd + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          if (msg_fire) begin
            if (msg.has_byte) begin
              count <= count + 61'd1;
            end
            fin <= msg.is_last;
          end
        end
        ST_PAD: begin
          padded   <= 1'b1;
          len_pend <= (pos[5:3] == 3'b111);
        end
        ST_UPD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
        end
        ST_LEN: begin
          len_pend <= 1'b0;
        end
        ST_EMIT: begin
          if (dig_fire) begin
            widx <= widx + 3'd1;
            if (widx == LAST_WORD) begin
              chain  <= H_INIT;
              count  <= '0;
              fin    <= 1'b0;
              padded <= 1'b0;
            end
          end
        end
        default: begin
          fin <= fin;
        end
      endcase
    end
  end

  // input and output sides never open together
  assert property (@(posedge clk) disable iff (rst) !(msg_ready && dig_valid))
    else $error("msg_ready and dig_valid both high");

  // taking the final digest word returns the engine to a fresh message
  assert property (@(posedge clk) disable iff (rst)
    dig_fire && dig.last_word |=> state == ST_IDLE && count == '0 && chain == H_INIT)
    else $error("engine not reset after final digest word");

  // the 64th round always hands off to the chaining add
  assert property (@(posedge clk) disable iff (rst)
    state == ST_COMP && rnd == LAST_ROUND |=> state == ST_UPD)
    else $error("compression did not end after 64 rounds");

  // every accepted byte bumps the count by one
  assert property (@(posedge clk) disable iff (rst)
    msg_fire && msg.has_byte |=> count == $past(count) + 61'd1)
    else $error("byte count did not advance");

  // a digest is only shown after padding
  assert property (@(posedge clk) disable iff (rst) dig_valid |-> padded && fin && !len_pend)
    else $error("digest shown before message finished");

endmodule

// ===== sv/sha256_sched.sv =====
`timescale 1ns / 1ps
// Block buffer and message schedule: byte packing, padding, length words,
// and a 16-word sliding window that yields one schedule word per round. Uses sha256_pkg.
module sha256_sched import sha256_pkg::*; (
  input  logic        clk,
  input  sched_ctl_t  ctl,
  input  logic [63:0] len_bits,
  output logic [31:0] w
);

  blk_words_t  blk;
  blk_words_t  blk_next;
  logic [3:0]  wi;
  logic [31:0] placed;
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] w_new;

  assign wi     = ctl.pos[5:2];
  assign placed = {ctl.byte_val, 24'd0} >> {ctl.pos[1:0], 3'd0};

  // window holds w[t..t+15]; w[t+16] from fixed taps
  assign s0    = rotr(blk[1], 7) ^ rotr(blk[1], 18) ^ (blk[1] >> 3);
  assign s1    = rotr(blk[14], 17) ^ rotr(blk[14], 19) ^ (blk[14] >> 10);
  assign w_new = blk[0] + s0 + blk[9] + s1;
  assign w     = blk[0];

  always_comb begin
    blk_next = blk;
    if (ctl.shift) begin
      for (int i = 0; i < 15; i++) begin
        blk_next[i] = blk[i + 1];
      end
      blk_next[15] = w_new;
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (ctl.byte_we && 4'(i) == wi) begin
          // first lane of a word overwrites it
          blk_next[i] = (ctl.pos[1:0] == 2'd0) ? placed : (blk[i] | placed);
        end else if (ctl.zero_tail && 4'(i) > wi) begin
          blk_next[i] = '0;
        end
        if (ctl.zero_low && i < 14) begin
          blk_next[i] = '0;
        end
      end
      if (ctl.len_we) begin
        blk_next[LEN_WORD_HI] = len_bits[63:32];
        blk_next[LEN_WORD_LO] = len_bits[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
  end

endmodule

// ===== sv/sha256_round.sv =====
`timescale 1ns / 1ps
// SHA-256 round unit: working variables a..h, one compression round per step.
// Uses sha256_pkg for the round constants and rotate helper.
module sha256_round import sha256_pkg::*; (
  input  logic        clk,
  input  round_ctl_t  ctl,
  input  hash_words_t chain,
  input  logic [31:0] w,
  output hash_words_t v
);

  hash_words_t v_next;
  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign big_s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign big_s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1     = v[7] + big_s1 + ch + K_TABLE[ctl.rnd] + w;
  assign t2     = big_s0 + maj;

  always_comb begin
    v_next    = v;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v <= chain;
    end else if (ctl.step) begin
      v <= v_next;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_hash_engine: byte beats in, digest words out.
// Depends on sha256_pkg for the beat types; carries its own SHA-256 model.
module tb_top;
  import sha256_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  typedef struct packed {
    msg_beat_t    beat;
    logic         known;   // digest typed in below
    logic [255:0] digest;
  } stim_row_t;

  localparam int N_DIRECTED = 13;
  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{'{8'h5a, 1'b0, 1'b0}, 1'b0, 256'h0},          // idle beat, no digest
    '{'{8'ha5, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},    // bare finish on fresh engine
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, 256'h0},          // idle inside a message
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},      // byte and finish together
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h7f, 1'b0, 1'b1}, 1'b0, 256'h0},          // bare finish after bytes
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, 256'h0},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, 256'h0},
    '{'{8'h3c, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST}     // back-to-back empty message
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      msg_valid = 1'b0;
  logic      msg_ready;
  msg_beat_t msg = '0;
  logic      dig_valid;
  logic      dig_ready = 1'b0;
  dig_beat_t dig;

  sha256_hash_engine DUT (
    .clk, .rst, .msg_valid, .msg_ready, .msg, .dig_valid, .dig_ready, .dig
  );

  always #10 clk = ~clk;

  // reference hash state
  logic [31:0] blk_buf [0:15];
  logic [31:0] chain_h [0:7];
  logic [60:0] byte_cnt;

  dig_beat_t digest_q[$];
  int        err_cnt = 0;
  int        beats_sent = 0;
  int        msgs_done = 0;
  int        words_checked = 0;
  bit        steady_tx = 1'b0;
  bit        hold_done = 1'b0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    logic [63:0] xx;
    xx = {x, x} >> n;
    return xx[31:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 16; i++) blk_buf[i] = '0;
    for (int i = 0; i < 8; i++) chain_h[i] = IV_H[i];
    byte_cnt = '0;
  endtask

  task automatic hash_compress();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;   // v[4] now holds old d
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic put_byte(input logic [5:0] pos, input logic [7:0] b);
    if (pos[1:0] == 2'd0) blk_buf[pos[5:2]] = {b, 24'h0};
    else blk_buf[pos[5:2]][31 - 8*pos[1:0] -: 8] = b;
  endtask

  // Absorb one accepted beat; on a finish returns the digest and rearms.
  task automatic hash_absorb(input msg_beat_t b, output bit fin, output logic [255:0] h);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    fin = 1'b0;
    h = '0;
    if (b.has_byte) begin
      pos = byte_cnt[5:0];
      put_byte(pos, b.data_byte);
      byte_cnt = byte_cnt + 61'd1;
      if (pos == 6'd63) hash_compress();
    end
    if (b.is_last) begin
      pos = byte_cnt[5:0];
      put_byte(pos, 8'h80);
      for (int i = int'(pos[5:2]) + 1; i < 16; i++) blk_buf[i] = '0;
      if (pos >= 6'd56) begin   // no room for the length: extra block
        hash_compress();
        for (int i = 0; i < 14; i++) blk_buf[i] = '0;
      end
      bit_len = {byte_cnt, 3'b000};
      blk_buf[14] = bit_len[63:32];
      blk_buf[15] = bit_len[31:0];
      hash_compress();
      for (int i = 0; i < 8; i++) h[255 - 32*i -: 32] = chain_h[i];
      fin = 1'b1;
      hash_reset();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH @%0t: %s got %h want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input msg_beat_t b, input logic known, input logic [255:0] want);
    int          gap;
    bit          fin;
    logic [255:0] h;
    dig_beat_t   w;
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_valid <= 1'b1;
    msg <= b;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    hash_absorb(b, fin, h);
    if (b.has_byte || b.is_last) beats_sent++;
    if (fin) begin
      if (known) h = want;
      for (int i = 0; i < 8; i++) begin
        w.digest_word = h[255 - 32*i -: 32];
        w.word_index = 3'(i);
        w.last_word = (i == 7);
        digest_q.insert(digest_q.size(), w);
      end
      msgs_done++;
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hff;
    return 8'($urandom);
  endfunction

  task automatic send_message(input int len);
    bit        tail_byte;
    msg_beat_t b;
    tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        b = '{8'($urandom), 1'b0, 1'b0};   // noise
        send_beat(b, 1'b0, '0);
      end
      b = '{pick_byte(), 1'b1, tail_byte && (k == len - 1)};
      send_beat(b, 1'b0, '0);
    end
    if (!tail_byte) begin
      b = '{8'($urandom), 1'b0, 1'b1};
      send_beat(b, 1'b0, '0);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return $urandom_range(0, 12);
    if (r < 90) return $urandom_range(55, 65);   // one-vs-two final blocks
    return $urandom_range(110, 130);
  endfunction

  initial begin : drive_msgs
    int rand_msgs;
    rand_msgs = 0;
    hash_reset();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    for (int r = 0; r < N_DIRECTED; r++)
      send_beat(DIRECTED[r].beat, DIRECTED[r].known, DIRECTED[r].digest);
    while (beats_sent < 310 || rand_msgs < 10) begin
      steady_tx = ($urandom_range(0, 4) == 0);
      send_message(pick_len());
      rand_msgs++;
    end
    msg_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d message beats, %0d messages hashed, %0d digest words checked",
             beats_sent, msgs_done, words_checked);
    $display("summary: %0d mismatches, long output stall %0s", err_cnt,
             hold_done ? "seen" : "not seen");
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin : drive_ready
    int n;
    wait (!rst);
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        dig_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      dig_ready <= 1'b1;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      repeat (n) @(negedge clk);
      // one long back-pressure stretch while the sender keeps pushing
      if (!hold_done && words_checked >= 24) begin
        dig_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_done = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_digest
    dig_beat_t want;
    if (!rst && dig_valid && dig_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest beat with nothing pending", dig.digest_word, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (dig.digest_word !== want.digest_word)
          report_mismatch("digest_word", dig.digest_word, want.digest_word);
        if (dig.word_index !== want.word_index)
          report_mismatch("word_index", 32'(dig.word_index), 32'(want.word_index));
        if (dig.last_word !== want.last_word)
          report_mismatch("last_word", 32'(dig.last_word), 32'(want.last_word));
        words_checked++;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
